// ===== design/awm_pkg.sv =====
// Shared constants, types and helpers for the anagram window matcher.
package awm_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int MAX_PATTERN   = 64;
    localparam int POSITION_BITS = 20;
    localparam int LETTER_W      = 5;
    localparam int COUNT_W       = $clog2(MAX_PATTERN + 2);
    localparam int PTR_W         = $clog2(MAX_PATTERN);

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2
    } op_t;

    typedef logic [LETTER_W-1:0]      letter_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [PTR_W-1:0]         ptr_t;
    typedef logic [POSITION_BITS-1:0] pos_t;

    typedef struct packed {
        logic    clear;
        logic    pat_add;
        logic    txt_add;
        logic    retire;
        letter_t letter;
        letter_t old;
    } hist_cmd_t;

    typedef struct packed {
        logic match_inc;
        logic match_dec;
    } hist_flags_t;

    function automatic ptr_t ring_next(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(MAX_PATTERN - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== design/awm_hist.sv =====
// Per-letter cells holding the needed and window histograms.
module awm_hist (
    input  logic                clk,
    input  logic                rst_n,
    input  awm_pkg::hist_cmd_t  cmd,
    output awm_pkg::hist_flags_t flags
);
    import awm_pkg::*;

    count_t                   need_reg [ALPHABET_SIZE];
    count_t                   win_reg  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] inc_vec;
    logic [ALPHABET_SIZE-1:0] dec_vec;

    for (genvar i = 0; i < ALPHABET_SIZE; i++)
    begin : g_cell
        logic   sel_l;
        logic   sel_o;
        logic   rdec;
        count_t need_inc;
        count_t wnew;
        count_t need_next;
        count_t win_next;

        always_comb
        begin
            sel_l      = (cmd.letter == letter_t'(i));
            sel_o      = (cmd.old == letter_t'(i));
            need_inc   = need_reg[i] + count_t'(1);
            wnew       = win_reg[i] + count_t'(cmd.txt_add && sel_l);
            rdec       = cmd.retire && sel_o && (wnew != '0);
            inc_vec[i] = (cmd.pat_add && sel_l && (win_reg[i] >= need_inc))
                       || (cmd.txt_add && sel_l && (wnew <= need_reg[i]));
            dec_vec[i] = rdec && (wnew <= need_reg[i]);
            if (cmd.clear)
            begin
                need_next = '0;
                win_next  = '0;
            end
            else
            begin
                need_next = (cmd.pat_add && sel_l) ? need_inc : need_reg[i];
                win_next  = rdec ? (wnew - count_t'(1)) : wnew;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                need_reg[i] <= '0;
                win_reg[i]  <= '0;
            end
            else
            begin
                need_reg[i] <= need_next;
                win_reg[i]  <= win_next;
            end
        end
    end

    assign flags.match_inc = |inc_vec;
    assign flags.match_dec = |dec_vec;

endmodule

// ===== design/awm_ring.sv =====
// Ring store of recent text letters with a prefetched oldest entry.
module awm_ring (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             push,
    input  logic             pop,
    input  awm_pkg::letter_t letter,
    output awm_pkg::letter_t head
);
    import awm_pkg::*;

    letter_t mem [MAX_PATTERN];
    ptr_t    wr_reg;
    ptr_t    rd_reg;
    ptr_t    wr_next;
    ptr_t    rd_next;
    letter_t head_reg;

    always_comb
    begin
        if (clear)
        begin
            wr_next = '0;
            rd_next = '0;
        end
        else
        begin
            wr_next = push ? ring_next(wr_reg) : wr_reg;
            rd_next = pop ? ring_next(rd_reg) : rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
    end

    // forward the word being written when it becomes the oldest entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= letter;
        end
        head_reg <= (push && (wr_reg == rd_next)) ? letter : mem[rd_next];
    end

    assign head = head_reg;

endmodule

// ===== design/anagram_window_matcher_unit.sv =====
// Sliding-window anagram search: input register, window update, result register.
// An accepted word waits in the input register until the output register is free; its
// result is presented from the output register. Throughput: one word per cycle unless
// m_tready stalls the output; the histogram cells and ring update in a single pass.
// Reset: asynchronous active-low reset empties all histograms, counters and positions.
// The ring memory holds no reset; a clear word rewinds its pointers.
module anagram_window_matcher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] letter, [7:5] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [19:0] start_index, [23:20] zero
);
    import awm_pkg::*;

    logic        in_valid_reg;
    op_t         in_op_reg;
    letter_t     in_letter_reg;
    logic        out_valid_reg;
    pos_t        out_index_reg;

    count_t      plen_reg;
    count_t      plen_next;
    count_t      matched_reg;
    count_t      matched_next;
    count_t      matched_mid;
    count_t      size_reg;
    count_t      size_next;
    pos_t        tpos_reg;
    pos_t        tpos_next;
    pos_t        wstart_reg;
    pos_t        wstart_next;

    logic        advance;
    logic        accept;
    logic        is_clear;
    logic        pat_ok;
    logic        is_text;
    logic        text_live;
    logic        retire;
    logic        hit;
    letter_t     old_letter;
    hist_cmd_t   cmd;
    hist_flags_t flags;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        is_clear  = 1'b0;
        pat_ok    = 1'b0;
        is_text   = 1'b0;
        unique case (in_op_reg)
            OP_CLEAR:   is_clear = advance;
            OP_PATTERN: pat_ok   = advance && (plen_reg < count_t'(MAX_PATTERN))
                                 && (in_letter_reg < letter_t'(ALPHABET_SIZE));
            OP_TEXT:    is_text  = advance;
            default:    ;
        endcase
        text_live = is_text && (plen_reg != '0);
        retire    = text_live && (size_reg >= plen_reg);
    end

    always_comb
    begin
        cmd.clear   = is_clear;
        cmd.pat_add = pat_ok;
        cmd.txt_add = text_live;
        cmd.retire  = retire;
        cmd.letter  = in_letter_reg;
        cmd.old     = old_letter;
    end

    awm_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .flags (flags)
    );

    awm_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (is_clear),
        .push   (text_live),
        .pop    (retire),
        .letter (in_letter_reg),
        .head   (old_letter)
    );

    always_comb
    begin
        matched_mid  = matched_reg + count_t'(flags.match_inc);
        matched_next = matched_mid
                     - count_t'(flags.match_dec && (matched_mid != '0));
        plen_next    = plen_reg + count_t'(pat_ok);
        size_next    = size_reg;
        tpos_next    = tpos_reg;
        wstart_next  = wstart_reg;
        if (is_text)
        begin
            tpos_next = tpos_reg + pos_t'(1);
            if (!text_live)
            begin
                wstart_next = tpos_next;
            end
            else
            begin
                size_next = size_reg + count_t'(1) - count_t'(retire);
                if (retire)
                begin
                    wstart_next = wstart_reg + pos_t'(1);
                end
            end
        end
        hit = text_live && (matched_next == plen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            plen_reg      <= '0;
            matched_reg   <= '0;
            size_reg      <= '0;
            tpos_reg      <= '0;
            wstart_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= hit;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (is_clear)
            begin
                plen_reg    <= '0;
                matched_reg <= '0;
                size_reg    <= '0;
                tpos_reg    <= '0;
                wstart_reg  <= '0;
            end
            else
            begin
                plen_reg    <= plen_next;
                matched_reg <= matched_next;
                size_reg    <= size_next;
                tpos_reg    <= tpos_next;
                wstart_reg  <= wstart_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg     <= op_t'(s_tuser);
            in_letter_reg <= s_tdata[LETTER_W-1:0];
        end
        if (advance)
        begin
            out_index_reg <= wstart_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_index_reg};

endmodule

// ===== dv/tb_anagram_window_matcher_unit.sv =====
// Self-checking testbench for anagram_window_matcher_unit: directed table, lead-in burst, random runs.
module tb_anagram_window_matcher_unit;

    import awm_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] EXP_PRED     = 2'd0;
    localparam logic [1:0] EXP_NONE     = 2'd1;
    localparam logic [1:0] EXP_HIT      = 2'd2;
    localparam int         RAND_WORDS   = 1620;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         LEAD_WORDS   = 32;

    typedef struct packed {
        logic [1:0] op;
        letter_t    letter;
        logic [1:0] kind;
        pos_t       want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    count_t  need_hist [0:ALPHABET_SIZE-1];
    count_t  win_hist [0:ALPHABET_SIZE-1];
    count_t  hits;
    count_t  pat_len;
    pos_t    txt_pos;
    pos_t    win_start;
    letter_t ring_letters [0:MAX_PATTERN-1];
    ptr_t    ring_wr_ptr;
    ptr_t    ring_rd_ptr;

    pos_t     start_index_q [$];
    dir_row_t dir_rows [0:24];
    int       mismatches;
    int       words_sent;
    int       quiet_cycles;
    bit       src_idle_en;
    bit       sink_idle_en;
    bit       hold_req;

    anagram_window_matcher_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic anagram_step(input logic [1:0] op, input letter_t l,
                                          output pos_t idx);
        pos_t    span;
        logic    retire;
        letter_t retired;
        idx = '0;
        if (op == OP_CLEAR)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                need_hist[i] = '0;
                win_hist[i]  = '0;
            end
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                ring_letters[i] = '0;
            end
            hits        = '0;
            pat_len     = '0;
            txt_pos     = '0;
            win_start   = '0;
            ring_wr_ptr = '0;
            ring_rd_ptr = '0;
            return 1'b0;
        end
        if (op == OP_PATTERN)
        begin
            if (pat_len < MAX_PATTERN && l < ALPHABET_SIZE)
            begin
                need_hist[l] = need_hist[l] + 1'b1;
                pat_len      = pat_len + 1'b1;
                if (win_hist[l] >= need_hist[l])
                begin
                    hits = hits + 1'b1;
                end
            end
            return 1'b0;
        end
        if (op != OP_TEXT)
        begin
            return 1'b0;
        end
        if (pat_len == 0)
        begin
            txt_pos   = txt_pos + 1'b1;
            win_start = txt_pos;
            return 1'b0;
        end
        span    = txt_pos - win_start;
        retire  = (span >= pat_len);
        retired = ring_letters[ring_rd_ptr];
        ring_letters[ring_wr_ptr] = l;
        ring_wr_ptr = ptr_t'((ring_wr_ptr + 1) % MAX_PATTERN);
        txt_pos     = txt_pos + 1'b1;
        if (l < ALPHABET_SIZE)
        begin
            win_hist[l] = win_hist[l] + 1'b1;
            if (win_hist[l] <= need_hist[l])
            begin
                hits = hits + 1'b1;
            end
        end
        if (retire)
        begin
            ring_rd_ptr = ptr_t'((ring_rd_ptr + 1) % MAX_PATTERN);
            win_start   = win_start + 1'b1;
            if (retired < ALPHABET_SIZE && win_hist[retired] > 0)
            begin
                if (win_hist[retired] <= need_hist[retired] && hits > 0)
                begin
                    hits = hits - 1'b1;
                end
                win_hist[retired] = win_hist[retired] - 1'b1;
            end
        end
        idx = win_start;
        return (hits == pat_len);
    endfunction

    task automatic send_word(input logic [1:0] op, input letter_t l, input logic [1:0] kind,
                             input pos_t want);
        pos_t idx;
        logic hit;
        while (src_idle_en && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, l};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        hit = anagram_step(op, l, idx);
        if (kind == EXP_HIT)
        begin
            start_index_q = {start_index_q, want};
        end
        else if (kind == EXP_PRED && hit)
        begin
            start_index_q = {start_index_q, idx};
        end
        if (op != OP_UNUSED)
        begin
            words_sent++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (start_index_q.size() == 0)
                begin
                    $display("%0t: unexpected start_index, expected none, got %0d",
                             $time, m_tdata[19:0]);
                    mismatches++;
                end
                else
                begin
                    if (m_tdata[19:0] !== start_index_q[0])
                    begin
                        $display("%0t: start_index mismatch, expected %0d, got %0d",
                                 $time, start_index_q[0], m_tdata[19:0]);
                        mismatches++;
                    end
                    void'(start_index_q.pop_front());
                end
            end
        end
    end

    // hold the receiver off on request so the block fills and stalls its input
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_tready <= sink_idle_en ? ($urandom_range(99) >= 30) : 1'b1;
        end
    end

    initial
    begin
        letter_t    pat_set [0:69];
        letter_t    l;
        logic [1:0] op;
        pos_t       idx;
        int         plen;
        int         tlen;
        int         base;
        int         spread;
        int         r;
        int         seq_no;
        int         stop_at;

        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        mismatches   = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_req     = 1'b0;
        void'(anagram_step(OP_CLEAR, '0, idx));

        dir_rows = '{
            {OP_TEXT,    5'd0,  EXP_NONE, 20'd0},
            {OP_UNUSED,  5'd31, EXP_NONE, 20'd0},
            {OP_PATTERN, 5'd0,  EXP_NONE, 20'd0},
            {OP_PATTERN, 5'd25, EXP_NONE, 20'd0},
            {OP_PATTERN, 5'd26, EXP_NONE, 20'd0},
            {OP_PATTERN, 5'd31, EXP_NONE, 20'd0},
            {OP_TEXT,    5'd25, EXP_PRED, 20'd0},
            {OP_TEXT,    5'd0,  EXP_HIT,  20'd1},
            {OP_TEXT,    5'd31, EXP_PRED, 20'd0},
            {OP_TEXT,    5'd25, EXP_PRED, 20'd0},
            {OP_TEXT,    5'd0,  EXP_PRED, 20'd0},
            {OP_PATTERN, 5'd0,  EXP_NONE, 20'd0},
            {OP_TEXT,    5'd0,  EXP_PRED, 20'd0},
            {OP_TEXT,    5'd25, EXP_PRED, 20'd0},
            {OP_UNUSED,  5'd10, EXP_NONE, 20'd0},
            {OP_CLEAR,   5'd0,  EXP_NONE, 20'd0},
            {OP_PATTERN, 5'd7,  EXP_NONE, 20'd0},
            {OP_TEXT,    5'd7,  EXP_HIT,  20'd0},
            {OP_TEXT,    5'd7,  EXP_PRED, 20'd0},
            {OP_CLEAR,   5'd31, EXP_NONE, 20'd0},
            {OP_TEXT,    5'd31, EXP_NONE, 20'd0},
            {OP_PATTERN, 5'd16, EXP_NONE, 20'd0},
            {OP_PATTERN, 5'd15, EXP_NONE, 20'd0},
            {OP_TEXT,    5'd16, EXP_PRED, 20'd0},
            {OP_TEXT,    5'd15, EXP_PRED, 20'd0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].op, dir_rows[i].letter, dir_rows[i].kind, dir_rows[i].want);
        end

        // advance the positions with an empty pattern, then match from there
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_word(OP_CLEAR, '0, EXP_NONE, '0);
        repeat (LEAD_WORDS)
        begin
            send_word(OP_TEXT, letter_t'($urandom_range(31)), EXP_NONE, '0);
        end
        send_word(OP_PATTERN, 5'd0, EXP_PRED, '0);
        send_word(OP_PATTERN, 5'd1, EXP_PRED, '0);
        for (int i = 0; i < 16; i++)
        begin
            send_word(OP_TEXT, letter_t'(i % 2), EXP_PRED, '0);
        end

        seq_no  = 0;
        stop_at = words_sent + RAND_WORDS;
        while (words_sent < stop_at)
        begin
            src_idle_en  = ($urandom_range(4) != 0);
            sink_idle_en = ($urandom_range(4) != 0);
            if (seq_no == 8 || seq_no == 40)
            begin
                hold_req = 1'b1;
            end
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(9) != 0)
                begin
                    send_word(OP_CLEAR, letter_t'($urandom_range(31)), EXP_PRED, '0);
                end
                plen   = ($urandom_range(9) == 0) ? $urandom_range(40, 70)
                                                  : $urandom_range(1, 8);
                base   = $urandom_range(0, 22);
                spread = $urandom_range(0, 3);
                for (int k = 0; k < plen; k++)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        pat_set[k] = letter_t'($urandom_range(31));
                    end
                    else
                    begin
                        pat_set[k] = letter_t'(base + $urandom_range(spread));
                    end
                    send_word(OP_PATTERN, pat_set[k], EXP_PRED, '0);
                end
                tlen = plen + $urandom_range(10, 60);
                for (int k = 0; k < tlen; k++)
                begin
                    r  = $urandom_range(99);
                    op = OP_TEXT;
                    if (r < 75)
                    begin
                        l = pat_set[$urandom_range(plen - 1)];
                    end
                    else if (r < 95)
                    begin
                        l = letter_t'($urandom_range(31));
                    end
                    else if (r < 98)
                    begin
                        op = OP_PATTERN;
                        l  = pat_set[$urandom_range(plen - 1)];
                    end
                    else
                    begin
                        op = OP_UNUSED;
                        l  = letter_t'($urandom_range(31));
                    end
                    send_word(op, l, EXP_PRED, '0);
                end
            end
            else
            begin
                repeat ($urandom_range(5, 20))
                begin
                    send_word(2'($urandom_range(3)), letter_t'($urandom_range(31)),
                              EXP_PRED, '0);
                end
            end
            seq_no++;
        end

        s_tvalid     <= 1'b0;
        sink_idle_en = 1'b1;
        while (start_index_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/awm_pkg.sv
design/awm_hist.sv
design/awm_ring.sv
design/anagram_window_matcher_unit.sv
dv/tb_anagram_window_matcher_unit.sv
